// File: sv/qspi_pkg.sv
// Shared types, constants, control-store program and arithmetic helpers.
package qspi_pkg;

  localparam int STEP_W = 5;
  localparam int ACC_W  = 73;
  localparam int GAIN_W = 24;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_SPEED,
    OP_PROD,
    OP_WINDUP,
    OP_INTEG,
    OP_PID,
    OP_CLAMP,
    OP_EDGE,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    G_SPEED,
    G_KP,
    G_KI,
    G_KB
  } gsel_t;

  typedef enum logic [1:0] {
    A_EDGES,
    A_ERR,
    A_SERR
  } asel_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_EDGE,
    JMP_ALWAYS
  } jmp_t;

  typedef struct packed {
    op_t               op;
    gsel_t             gsel;
    asel_t             asel;
    logic              hi;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    op_t   op;
    gsel_t gsel;
    asel_t asel;
    logic  hi;
    logic  fire;
  } issue_t;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] MODE_FWD = 2'd1;
  localparam logic [1:0] MODE_REV = 2'd2;

  localparam logic [1:0] PINS_FWD = 2'b01;
  localparam logic [1:0] PINS_REV = 2'b10;

  localparam logic [2:0] REG_COUNTS_PER_REV = 3'd0;
  localparam logic [2:0] REG_SPEED_SCALE    = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN      = 3'd2;
  localparam logic [2:0] REG_INT_GAIN       = 3'd3;
  localparam logic [2:0] REG_BACKCALC_GAIN  = 3'd4;
  localparam logic [2:0] REG_DUTY_MAX       = 3'd5;

  localparam logic [12:0] COUNTS_PER_REV_RST = 13'd990;
  localparam logic [23:0] SPEED_SCALE_RST    = 24'd99297;
  localparam logic [23:0] PROP_GAIN_RST      = 24'd32768;
  localparam logic [23:0] INT_GAIN_RST       = 24'd131;
  localparam logic [23:0] BACKCALC_GAIN_RST  = 24'd7864;
  localparam logic [15:0] DUTY_MAX_RST       = 16'd100;

  localparam logic [STEP_W-1:0] ADDR_EDGE = 5'd15;
  localparam logic [STEP_W-1:0] ADDR_EMIT = 5'd16;

  typedef struct packed {
    logic [12:0] counts_per_rev;
    logic [23:0] speed_scale;
    logic [23:0] proportional_gain;
    logic [23:0] integral_gain_dt;
    logic [23:0] backcalc_gain_dt;
    logic [15:0] duty_max;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic               phase_a;
    logic               phase_b;
    logic signed [15:0] target_rpm;
    logic [1:0]         direction_mode;
  } item_t;

  typedef struct packed {
    logic [23:0]        measured_rpm;
    logic signed [31:0] revolutions;
    logic signed [15:0] count_in_rev;
    logic               reverse_drive;
    logic               forward_drive;
    logic [15:0]        duty;
  } result_t;

  function automatic logic [1:0] fwd_pred(input logic [1:0] st);
    logic [1:0] p;
    case (st)
      2'd0:    p = 2'd1;
      2'd1:    p = 2'd3;
      2'd2:    p = 2'd0;
      default: p = 2'd2;
    endcase
    return p;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    logic signed [47:0]      r;
    hi_lim = {{(ACC_W-47){1'b0}}, {47{1'b1}}};
    lo_lim = ~hi_lim;
    if (x > hi_lim) begin
      r = hi_lim[47:0];
    end else if (x < lo_lim) begin
      r = lo_lim[47:0];
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sx48(input logic signed [47:0] v);
    return {{(ACC_W-48){v[47]}}, v};
  endfunction

  function automatic ctrl_t mk_word(input op_t op, input gsel_t g, input asel_t a,
                                    input logic hi, input jmp_t j,
                                    input logic [STEP_W-1:0] tgt);
    ctrl_t w;
    w.op     = op;
    w.gsel   = g;
    w.asel   = a;
    w.hi     = hi;
    w.jmp    = j;
    w.target = tgt;
    return w;
  endfunction

  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] addr);
    ctrl_t w;
    case (addr)
      5'd0:  w = mk_word(OP_NOP,    G_SPEED, A_EDGES, 1'b0, JMP_EDGE,   ADDR_EDGE);
      5'd1:  w = mk_word(OP_MUL,    G_SPEED, A_EDGES, 1'b0, JMP_NONE,   '0);
      5'd2:  w = mk_word(OP_MUL,    G_SPEED, A_EDGES, 1'b1, JMP_NONE,   '0);
      5'd3:  w = mk_word(OP_SPEED,  G_SPEED, A_EDGES, 1'b0, JMP_NONE,   '0);
      5'd4:  w = mk_word(OP_MUL,    G_KI,    A_ERR,   1'b0, JMP_NONE,   '0);
      5'd5:  w = mk_word(OP_MUL,    G_KI,    A_ERR,   1'b1, JMP_NONE,   '0);
      5'd6:  w = mk_word(OP_PROD,   G_KI,    A_ERR,   1'b0, JMP_NONE,   '0);
      5'd7:  w = mk_word(OP_MUL,    G_KB,    A_SERR,  1'b0, JMP_NONE,   '0);
      5'd8:  w = mk_word(OP_MUL,    G_KB,    A_SERR,  1'b1, JMP_NONE,   '0);
      5'd9:  w = mk_word(OP_WINDUP, G_KB,    A_SERR,  1'b0, JMP_NONE,   '0);
      5'd10: w = mk_word(OP_INTEG,  G_KB,    A_SERR,  1'b0, JMP_NONE,   '0);
      5'd11: w = mk_word(OP_MUL,    G_KP,    A_ERR,   1'b0, JMP_NONE,   '0);
      5'd12: w = mk_word(OP_MUL,    G_KP,    A_ERR,   1'b1, JMP_NONE,   '0);
      5'd13: w = mk_word(OP_PID,    G_KP,    A_ERR,   1'b0, JMP_NONE,   '0);
      5'd14: w = mk_word(OP_CLAMP,  G_KP,    A_ERR,   1'b0, JMP_ALWAYS, ADDR_EMIT);
      5'd15: w = mk_word(OP_EDGE,   G_SPEED, A_EDGES, 1'b0, JMP_NONE,   '0);
      default: w = mk_word(OP_EMIT, G_SPEED, A_EDGES, 1'b0, JMP_NONE,   '0);
    endcase
    return w;
  endfunction

endpackage

// File: sv/qspi_seq.sv
// Microcode sequencer: step counter, control store lookup and jumps.
module qspi_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          edge_cmd,
  input  logic                          emit_ok,
  output logic                          busy,
  output qspi_pkg::issue_t              issue
);

  logic [qspi_pkg::STEP_W-1:0] step;
  logic [qspi_pkg::STEP_W-1:0] step_next;
  qspi_pkg::ctrl_t             word;

  always_comb begin
    word = qspi_pkg::rom_word(step);
    case (word.jmp)
      qspi_pkg::JMP_EDGE:   step_next = (edge_cmd == qspi_pkg::CMD_EDGE) ? word.target
                                                                          : step + 1'b1;
      qspi_pkg::JMP_ALWAYS: step_next = word.target;
      default:              step_next = step + 1'b1;
    endcase
    issue.op   = word.op;
    issue.gsel = word.gsel;
    issue.asel = word.asel;
    issue.hi   = word.hi;
    issue.fire = busy && ((word.op != qspi_pkg::OP_EMIT) || emit_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (word.op == qspi_pkg::OP_EMIT) begin
        if (emit_ok) begin
          busy <= 1'b0;
        end
      end else begin
        step <= step_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (busy && word.op == qspi_pkg::OP_EMIT && !emit_ok) |=> (busy && $stable(step)))
    else $error("sequencer left a stalled result step");

endmodule

// File: sv/qspi_datapath.sv
// Datapath: quadrature counter, shared gain multiplier, PI state and clamp.
module qspi_datapath #(
  parameter int REV_WIDTH  = 32,
  parameter int EDGE_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  qspi_pkg::issue_t  issue,
  input  qspi_pkg::cfg_t    cfg,
  input  qspi_pkg::item_t   item,
  output qspi_pkg::result_t result
);

  localparam int AW    = qspi_pkg::ACC_W;
  localparam int LSW   = EDGE_WIDTH + qspi_pkg::GAIN_W;
  localparam int RW    = LSW - FRAC_BITS;
  localparam int RPM_W = RW + 24;

  logic [1:0]              prev_phase;
  logic signed [15:0]      pos;
  logic [REV_WIDTH-1:0]    rev_cnt;
  logic [EDGE_WIDTH-1:0]   edges;
  logic [LSW-1:0]          last_speed;
  logic signed [47:0]      integ;
  logic signed [47:0]      serr;
  logic signed [47:0]      p1;
  logic signed [47:0]      err;
  logic signed [AW-1:0]    acc;
  logic [15:0]             duty;
  logic [1:0]              pins;

  logic [23:0]             gain;
  logic signed [24:0]      gain_s;
  logic signed [47:0]      a48;
  logic signed [24:0]      chunk;
  logic signed [49:0]      prod;
  logic signed [AW-1:0]    prod_x;
  logic signed [AW-1:0]    acc_next;
  logic signed [AW-1:0]    shifted;
  logic signed [47:0]      prod48;
  logic signed [AW-1:0]    target_x;
  logic signed [AW-1:0]    speed_x;
  logic signed [47:0]      err_next;
  logic signed [AW-1:0]    pid_x;
  logic signed [AW-1:0]    top_x;
  logic signed [AW-1:0]    sat_x;
  logic signed [AW-1:0]    sat_sh;
  logic signed [47:0]      serr_next;
  logic [15:0]             duty_now;
  logic [1:0]              st;
  logic                    fwd;
  logic signed [16:0]      pos_x;
  logic signed [16:0]      limit_x;
  logic                    wrap_up;
  logic                    wrap_dn;
  logic [RW-1:0]           rpm_full;
  logic [RPM_W-1:0]        rpm_ext;
  logic signed [63:0]      rev_sx;

  always_comb begin
    case (issue.gsel)
      qspi_pkg::G_SPEED: gain = cfg.speed_scale;
      qspi_pkg::G_KP:    gain = cfg.proportional_gain;
      qspi_pkg::G_KI:    gain = cfg.integral_gain_dt;
      default:           gain = cfg.backcalc_gain_dt;
    endcase
    case (issue.asel)
      qspi_pkg::A_EDGES: a48 = {{(48-EDGE_WIDTH){1'b0}}, edges};
      qspi_pkg::A_SERR:  a48 = serr;
      default:           a48 = err;
    endcase
    gain_s   = {1'b0, gain};
    chunk    = issue.hi ? {a48[47], a48[47:24]} : {1'b0, a48[23:0]};
    prod     = gain_s * chunk;
    prod_x   = {{(AW-50){prod[49]}}, prod};
    acc_next = issue.hi ? acc + (prod_x <<< 24) : prod_x;
    shifted  = acc >>> FRAC_BITS;
    prod48   = qspi_pkg::sat48(shifted);

    target_x = {{(AW-16){item.target_rpm[15]}}, item.target_rpm} <<< FRAC_BITS;
    speed_x  = {{(AW-LSW){1'b0}}, acc[LSW-1:0]};
    err_next = qspi_pkg::sat48(target_x - speed_x);

    pid_x = qspi_pkg::sx48(p1);
    top_x = {{(AW-16){1'b0}}, cfg.duty_max} <<< FRAC_BITS;
    if (pid_x > top_x) begin
      sat_x = top_x;
    end else if (pid_x[AW-1]) begin
      sat_x = '0;
    end else begin
      sat_x = pid_x;
    end
    serr_next = qspi_pkg::sat48(sat_x - pid_x);
    sat_sh    = sat_x >>> FRAC_BITS;
    duty_now  = sat_sh[15:0];

    st      = {item.phase_a, item.phase_b};
    fwd     = (prev_phase == qspi_pkg::fwd_pred(st));
    pos_x   = {pos[15], pos} + (fwd ? 17'sd1 : -17'sd1);
    limit_x = {2'b00, cfg.counts_per_rev, 2'b00};
    wrap_up = (pos_x >= limit_x);
    wrap_dn = (pos_x <= -limit_x);

    rpm_full = last_speed[LSW-1:FRAC_BITS];
    rpm_ext  = {{24{1'b0}}, rpm_full};
    rev_sx   = 64'(signed'(rev_cnt));

    result.duty          = duty;
    result.forward_drive = pins[0];
    result.reverse_drive = pins[1];
    result.count_in_rev  = pos;
    result.revolutions   = rev_sx[31:0];
    result.measured_rpm  = (rpm_ext > RPM_W'(24'hFFFFFF)) ? 24'hFFFFFF : rpm_ext[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase <= '0;
      pos        <= '0;
      rev_cnt    <= '0;
      edges      <= '0;
      last_speed <= '0;
      integ      <= '0;
      serr       <= '0;
      duty       <= '0;
      pins       <= '0;
    end else if (issue.fire) begin
      case (issue.op)
        qspi_pkg::OP_MUL: begin
          acc <= acc_next;
        end
        qspi_pkg::OP_SPEED: begin
          last_speed <= acc[LSW-1:0];
          edges      <= '0;
          err        <= err_next;
        end
        qspi_pkg::OP_PROD: begin
          p1 <= prod48;
        end
        qspi_pkg::OP_WINDUP: begin
          p1 <= qspi_pkg::sat48(qspi_pkg::sx48(p1) + qspi_pkg::sx48(prod48));
        end
        qspi_pkg::OP_INTEG: begin
          integ <= qspi_pkg::sat48(qspi_pkg::sx48(integ) + qspi_pkg::sx48(p1));
        end
        qspi_pkg::OP_PID: begin
          p1 <= qspi_pkg::sat48(qspi_pkg::sx48(prod48) + qspi_pkg::sx48(integ));
        end
        qspi_pkg::OP_CLAMP: begin
          serr <= serr_next;
          if (item.direction_mode == qspi_pkg::MODE_FWD) begin
            pins <= qspi_pkg::PINS_FWD;
            duty <= duty_now;
          end else if (item.direction_mode == qspi_pkg::MODE_REV) begin
            pins <= qspi_pkg::PINS_REV;
            duty <= duty_now;
          end else begin
            duty <= '0;
          end
        end
        qspi_pkg::OP_EDGE: begin
          prev_phase <= st;
          if (edges != '1) begin
            edges <= edges + 1'b1;
          end
          if (wrap_up) begin
            pos     <= '0;
            rev_cnt <= rev_cnt + 1'b1;
          end else if (wrap_dn) begin
            pos     <= '0;
            rev_cnt <= rev_cnt - 1'b1;
          end else begin
            pos <= pos_x[15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot0(pins))
    else $error("both direction pins driven");

  assert property (@(posedge clk) disable iff (rst)
    (issue.fire && issue.op == qspi_pkg::OP_SPEED) |=> (edges == '0))
    else $error("edge window not cleared after speed update");

endmodule

// File: sv/quadrature_speed_pi_loop_core.sv
// Quadrature encoder counter with PI speed loop, one motor channel.
// An edge transfer runs a dispatch step and the edge update, then the result; a tick
// runs 15 control-store steps through one shared 25x25 multiplier, then the result.
// Throughput: one item at a time; the next transfer is taken once the result
// is in the output register, which may still be waiting on m_tready.
// Reset (rst, synchronous): config registers to defaults, counter and PI state to zero.
module quadrature_speed_pi_loop_core #(
  parameter int REV_WIDTH  = 32,
  parameter int EDGE_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // phase_a, phase_b, target_rpm[15:0], direction_mode[1:0]
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // duty[15:0], forward_drive, reverse_drive,
                                 // count_in_rev[15:0], revolutions[31:0], measured_rpm[23:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  qspi_pkg::cfg_t    cfg;
  qspi_pkg::item_t   item;
  qspi_pkg::issue_t  issue;
  qspi_pkg::result_t result;
  logic              busy;
  logic              accept;
  logic              emit_ok;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign emit_ok  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counts_per_rev    <= qspi_pkg::COUNTS_PER_REV_RST;
      cfg.speed_scale       <= qspi_pkg::SPEED_SCALE_RST;
      cfg.proportional_gain <= qspi_pkg::PROP_GAIN_RST;
      cfg.integral_gain_dt  <= qspi_pkg::INT_GAIN_RST;
      cfg.backcalc_gain_dt  <= qspi_pkg::BACKCALC_GAIN_RST;
      cfg.duty_max          <= qspi_pkg::DUTY_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qspi_pkg::REG_COUNTS_PER_REV: cfg.counts_per_rev    <= cfg_data[12:0];
        qspi_pkg::REG_SPEED_SCALE:    cfg.speed_scale       <= cfg_data;
        qspi_pkg::REG_PROP_GAIN:      cfg.proportional_gain <= cfg_data;
        qspi_pkg::REG_INT_GAIN:       cfg.integral_gain_dt  <= cfg_data;
        qspi_pkg::REG_BACKCALC_GAIN:  cfg.backcalc_gain_dt  <= cfg_data;
        qspi_pkg::REG_DUTY_MAX:       cfg.duty_max          <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.command        <= s_tuser;
      item.phase_a        <= s_tdata[0];
      item.phase_b        <= s_tdata[1];
      item.target_rpm     <= s_tdata[17:2];
      item.direction_mode <= s_tdata[19:18];
    end
  end

  qspi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .edge_cmd (item.command),
    .emit_ok  (emit_ok),
    .busy     (busy),
    .issue    (issue)
  );

  qspi_datapath #(
    .REV_WIDTH  (REV_WIDTH),
    .EDGE_WIDTH (EDGE_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (issue.fire && issue.op == qspi_pkg::OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.fire && issue.op == qspi_pkg::OP_EMIT) begin
      m_tdata <= {6'b0, result.measured_rpm, result.revolutions, result.count_in_rev,
                  result.reverse_drive, result.forward_drive, result.duty};
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> !s_tready)
    else $error("transfer taken while item in progress");

  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(busy))
    else $error("result produced with no item in progress");

endmodule

// File: test/tb_quadrature_speed_pi_loop_core.sv
// Self-checking testbench for the quadrature counter and PI speed loop core.
module tb_quadrature_speed_pi_loop_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS       = 16;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int RANDOM_PHASES   = 8;
  localparam int WINDOW_RUN      = 150;
  localparam int LONG_HOLD       = 300;
  localparam int TAIL_CYCLES     = 24;
  localparam int STALL_LIMIT     = 2000;

  localparam logic [1:0] MODE_STOP     = 2'd0;
  localparam logic [1:0] MODE_STOP_ALT = 2'd3;

  class speed_loop_tracker;
    localparam logic signed [95:0] S48_HI = (96'sd1 <<< 47) - 96'sd1;
    localparam logic signed [95:0] S48_LO = -(96'sd1 <<< 47);

    qspi_pkg::cfg_t     cfg;
    logic [1:0]         phase_state;
    int                 position;
    logic [31:0]        rev_count;
    logic [15:0]        edge_window;
    logic [39:0]        speed_q;
    logic signed [95:0] integral;
    logic signed [95:0] sat_error;
    logic [15:0]        duty;
    logic [1:0]         pins;
    qspi_pkg::result_t  expected_status[$];
    int                 errors;
    int                 results_checked;
    int                 ticks;
    int                 edges;

    function new();
      cfg.counts_per_rev    = qspi_pkg::COUNTS_PER_REV_RST;
      cfg.speed_scale       = qspi_pkg::SPEED_SCALE_RST;
      cfg.proportional_gain = qspi_pkg::PROP_GAIN_RST;
      cfg.integral_gain_dt  = qspi_pkg::INT_GAIN_RST;
      cfg.backcalc_gain_dt  = qspi_pkg::BACKCALC_GAIN_RST;
      cfg.duty_max          = qspi_pkg::DUTY_MAX_RST;
      phase_state = '0;
      position    = 0;
      rev_count   = '0;
      edge_window = '0;
      speed_q     = '0;
      integral    = '0;
      sat_error   = '0;
      duty        = '0;
      pins        = '0;
      errors = 0;
      results_checked = 0;
      ticks = 0;
      edges = 0;
    endfunction

    function logic signed [95:0] clip48(logic signed [95:0] x);
      if (x > S48_HI) return S48_HI;
      if (x < S48_LO) return S48_LO;
      return x;
    endfunction

    function logic signed [95:0] apply_gain(logic [23:0] g, logic signed [95:0] x);
      logic signed [95:0] p;
      p = $signed({72'd0, g}) * x;
      return clip48(p >>> FRAC_BITS);
    endfunction

    // Forward rotation walks the states 0, 2, 3, 1.
    function logic [1:0] forward_next(logic [1:0] s);
      case (s)
        2'd0:    return 2'd2;
        2'd2:    return 2'd3;
        2'd3:    return 2'd1;
        default: return 2'd0;
      endcase
    endfunction

    function void step_encoder(logic [1:0] st);
      int limit;
      limit = 4 * int'(cfg.counts_per_rev);
      if (forward_next(phase_state) == st) position++;
      else position--;
      phase_state = st;
      if (edge_window != 16'hFFFF) edge_window++;
      if (position >= limit) begin
        position = 0;
        rev_count++;
      end else if (position <= -limit) begin
        position = 0;
        rev_count--;
      end
    endfunction

    function void step_speed_loop(logic signed [15:0] target, logic [1:0] mode);
      logic signed [95:0] tgt;
      logic signed [95:0] err;
      logic signed [95:0] pid;
      logic signed [95:0] clamped;
      logic signed [95:0] ceiling;
      logic [15:0]        candidate;
      speed_q = 40'(edge_window) * 40'(cfg.speed_scale);
      edge_window = '0;
      tgt = target;
      err = clip48((tgt <<< FRAC_BITS) - $signed({56'd0, speed_q}));
      integral = clip48(integral + clip48(apply_gain(cfg.integral_gain_dt, err) +
                                          apply_gain(cfg.backcalc_gain_dt, sat_error)));
      pid = clip48(apply_gain(cfg.proportional_gain, err) + integral);
      ceiling = $signed({80'd0, cfg.duty_max}) <<< FRAC_BITS;
      clamped = pid;
      if (clamped > ceiling) clamped = ceiling;
      if (clamped < 0) clamped = '0;
      sat_error = clip48(clamped - pid);
      candidate = clamped[FRAC_BITS +: 16];
      case (mode)
        qspi_pkg::MODE_FWD: begin
          pins = qspi_pkg::PINS_FWD;
          duty = candidate;
        end
        qspi_pkg::MODE_REV: begin
          pins = qspi_pkg::PINS_REV;
          duty = candidate;
        end
        default: begin
          duty = '0;
        end
      endcase
    endfunction

    function void note_item(qspi_pkg::item_t it);
      qspi_pkg::result_t r;
      if (it.command == qspi_pkg::CMD_TICK) begin
        ticks++;
        step_speed_loop(it.target_rpm, it.direction_mode);
      end else begin
        edges++;
        step_encoder({it.phase_a, it.phase_b});
      end
      r.duty          = duty;
      r.forward_drive = pins[0];
      r.reverse_drive = pins[1];
      r.count_in_rev  = position[15:0];
      r.revolutions   = rev_count;
      r.measured_rpm  = speed_q[39:16];
      expected_status.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                         results_checked, name, got, want));
    endtask

    task check_result(logic [95:0] bus);
      qspi_pkg::result_t got;
      qspi_pkg::result_t want;
      got = bus[89:0];
      results_checked++;
      if (bus[95:90] != '0) report($sformatf("result %0d: nonzero padding", results_checked));
      if (expected_status.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", results_checked));
        return;
      end
      want = expected_status.pop_front();
      compare_field("duty", got.duty, want.duty);
      compare_field("forward_drive", got.forward_drive, want.forward_drive);
      compare_field("reverse_drive", got.reverse_drive, want.reverse_drive);
      compare_field("count_in_rev", got.count_in_rev, want.count_in_rev);
      compare_field("revolutions", got.revolutions, want.revolutions);
      compare_field("measured_rpm", got.measured_rpm, want.measured_rpm);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  speed_loop_tracker tracker;
  int  items_sent = 0;
  int  settings_applied = 0;
  int  stall_requests = 0;
  int  quiet_cycles = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  logic [1:0] enc_state = '0;

  quadrature_speed_pi_loop_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic logic [1:0] gray_next(logic [1:0] s, bit up);
    case (s)
      2'd0:    return up ? 2'd2 : 2'd1;
      2'd1:    return up ? 2'd0 : 2'd3;
      2'd2:    return up ? 2'd3 : 2'd0;
      default: return up ? 2'd1 : 2'd2;
    endcase
  endfunction

  function automatic qspi_pkg::item_t edge_of(logic [1:0] st);
    qspi_pkg::item_t it;
    it.command        = qspi_pkg::CMD_EDGE;
    it.phase_a        = st[1];
    it.phase_b        = st[0];
    it.target_rpm     = 16'($urandom);
    it.direction_mode = 2'($urandom);
    return it;
  endfunction

  function automatic qspi_pkg::item_t tick_of(logic signed [15:0] tgt, logic [1:0] mode);
    qspi_pkg::item_t it;
    it.command        = qspi_pkg::CMD_TICK;
    it.phase_a        = 1'($urandom);
    it.phase_b        = 1'($urandom);
    it.target_rpm     = tgt;
    it.direction_mode = mode;
    return it;
  endfunction

  function automatic logic [23:0] pick_value(int bits, logic [23:0] dflt);
    logic [23:0] full;
    full = 24'((1 << bits) - 1);
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return full;
      2:       return dflt;
      3, 4:    return 24'($urandom) & 24'((1 << $urandom_range(1, bits)) - 1);
      default: return 24'($urandom) & full;
    endcase
  endfunction

  function automatic qspi_pkg::cfg_t random_settings();
    qspi_pkg::cfg_t c;
    logic [23:0]    v;
    v = pick_value(13, 24'(qspi_pkg::COUNTS_PER_REV_RST));
    c.counts_per_rev    = v[12:0];
    c.speed_scale       = pick_value(24, qspi_pkg::SPEED_SCALE_RST);
    c.proportional_gain = pick_value(24, qspi_pkg::PROP_GAIN_RST);
    c.integral_gain_dt  = pick_value(24, qspi_pkg::INT_GAIN_RST);
    c.backcalc_gain_dt  = pick_value(24, qspi_pkg::BACKCALC_GAIN_RST);
    v = pick_value(16, 24'(qspi_pkg::DUTY_MAX_RST));
    c.duty_max          = v[15:0];
    return c;
  endfunction

  task automatic send_item(qspi_pkg::item_t it);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.command;
    s_tdata  <= {4'd0, it.direction_mode, it.target_rpm, it.phase_b, it.phase_a};
    items_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.results_checked < items_sent) @(posedge clk);
  endtask

  // Upper data bits beyond each register's width carry junk; an out-of-range index ends the set.
  task automatic apply_settings(qspi_pkg::cfg_t c);
    logic [2:0]  idx;
    logic [23:0] d;
    for (int i = 0; i <= 6; i++) begin
      idx = 3'(i);
      d   = 24'($urandom);
      case (idx)
        qspi_pkg::REG_COUNTS_PER_REV: d[12:0] = c.counts_per_rev;
        qspi_pkg::REG_SPEED_SCALE:    d = c.speed_scale;
        qspi_pkg::REG_PROP_GAIN:      d = c.proportional_gain;
        qspi_pkg::REG_INT_GAIN:       d = c.integral_gain_dt;
        qspi_pkg::REG_BACKCALC_GAIN:  d = c.backcalc_gain_dt;
        qspi_pkg::REG_DUTY_MAX:       d[15:0] = c.duty_max;
        default:                      idx = 3'($urandom_range(6, 7));
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    tracker.cfg = c;
    settings_applied++;
  endtask

  always @(posedge clk) begin
    qspi_pkg::item_t seen;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.command        = s_tuser;
        seen.phase_a        = s_tdata[0];
        seen.phase_b        = s_tdata[1];
        seen.target_rpm     = s_tdata[17:2];
        seen.direction_mode = s_tdata[19:18];
        tracker.note_item(seen);
      end
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
    end
  end

  initial begin
    int hold;
    int gap;
    int stalls_taken;
    hold = 0;
    gap = 0;
    stalls_taken = 0;
    forever begin
      @(posedge clk);
      if (stalls_taken != stall_requests) begin
        stalls_taken = stall_requests;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    qspi_pkg::cfg_t     c;
    int                 t;
    int unsigned        edges_to_tick;
    logic signed [15:0] base_target;
    logic signed [15:0] tgt;
    logic [1:0]         mode;
    bit                 fwd_dir;
    int unsigned        r;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: both rotation senses, a repeated state, every mode.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(edge_of(2'd2));
    send_item(edge_of(2'd3));
    send_item(edge_of(2'd1));
    send_item(edge_of(2'd0));
    send_item(edge_of(2'd0));
    send_item(edge_of(2'd1));
    send_item(tick_of(16'sh7FFF, qspi_pkg::MODE_FWD));
    send_item(tick_of(16'sh8000, qspi_pkg::MODE_REV));
    send_item(tick_of(16'sd1000, MODE_STOP));
    send_item(tick_of(16'sd1000, MODE_STOP_ALT));
    send_item(tick_of(16'sd0, qspi_pkg::MODE_FWD));

    // Zero line count and zero duty ceiling, all gains at full scale.
    drain();
    c.counts_per_rev    = '0;
    c.speed_scale       = '1;
    c.proportional_gain = '1;
    c.integral_gain_dt  = '1;
    c.backcalc_gain_dt  = '1;
    c.duty_max          = '0;
    apply_settings(c);
    send_item(edge_of(2'd0));
    send_item(edge_of(2'd2));
    send_item(edge_of(2'd0));
    send_item(edge_of(2'd0));
    send_item(tick_of(16'sh7FFF, qspi_pkg::MODE_FWD));
    send_item(tick_of(16'sh8000, qspi_pkg::MODE_REV));
    send_item(tick_of(16'sh7FFF, qspi_pkg::MODE_FWD));

    // Smallest nonzero line count, widest duty range.
    drain();
    c.counts_per_rev    = 13'd1;
    c.proportional_gain = qspi_pkg::PROP_GAIN_RST;
    c.integral_gain_dt  = qspi_pkg::INT_GAIN_RST;
    c.backcalc_gain_dt  = qspi_pkg::BACKCALC_GAIN_RST;
    c.duty_max          = '1;
    apply_settings(c);
    send_item(edge_of(2'd2));
    send_item(edge_of(2'd3));
    send_item(edge_of(2'd1));
    send_item(edge_of(2'd0));
    send_item(edge_of(2'd1));
    send_item(edge_of(2'd3));
    send_item(tick_of(16'sh7FFF, qspi_pkg::MODE_FWD));
    enc_state = 2'd3;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      apply_settings(random_settings());
      tx_idle = (phase % 4) != 3;
      rx_idle = (phase % 4) != 2;
      t = $urandom_range(0, 6000);
      t = t - 3000;
      base_target = t[15:0];
      fwd_dir = 1'($urandom);
      edges_to_tick = $urandom_range(0, 30);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 2 && k == 50) stall_requests++;
        if (phase == 5 && k == 60) drain();
        if (edges_to_tick == 0) begin
          edges_to_tick = $urandom_range(0, 30);
          if ($urandom_range(0, 3) == 0) begin
            tgt = 16'($urandom);
          end else begin
            t = int'(base_target) + int'($urandom_range(0, 200)) - 100;
            tgt = t[15:0];
          end
          case ($urandom_range(0, 9))
            0:          mode = MODE_STOP;
            1:          mode = MODE_STOP_ALT;
            2, 3, 4, 5: mode = qspi_pkg::MODE_FWD;
            default:    mode = qspi_pkg::MODE_REV;
          endcase
          send_item(tick_of(tgt, mode));
        end else begin
          edges_to_tick--;
          r = $urandom_range(0, 24);
          if (r == 1) fwd_dir = !fwd_dir;
          if (r == 0) enc_state = 2'($urandom);
          else enc_state = gray_next(enc_state, fwd_dir);
          send_item(edge_of(enc_state));
        end
      end
    end

    // Long forward run with the line count and scale at their maximum.
    drain();
    c = random_settings();
    c.counts_per_rev = '1;
    c.speed_scale    = '1;
    apply_settings(c);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (WINDOW_RUN) begin
      enc_state = gray_next(enc_state, 1'b1);
      send_item(edge_of(enc_state));
    end
    send_item(tick_of(16'sh7FFF, qspi_pkg::MODE_FWD));
    send_item(tick_of(16'sh8000, qspi_pkg::MODE_REV));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.expected_status.size() != 0)
      tracker.report($sformatf("%0d expected results never arrived",
                               tracker.expected_status.size()));
    $display("Covered %0d edge and %0d tick transfers under %0d register settings, %0d results",
             tracker.edges, tracker.ticks, settings_applied, tracker.results_checked);
    $display("checked, with %0d long output hold-off(s) and a full-scale forward run; %0d errors",
             stall_requests, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/qspi_pkg.sv
sv/qspi_seq.sv
sv/qspi_datapath.sv
sv/quadrature_speed_pi_loop_core.sv
test/tb_quadrature_speed_pi_loop_core.sv
